// ===== design/assert_macros.svh =====
// shared assertion macros for the grid step block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define RGS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgs assertion failed");

// next-cycle implication, off during reset
`define RGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgs assertion failed");

`endif

// ===== design/rgs_pkg.sv =====
// ----------------------------------------------------------------------------
// rgs_pkg
// shared constants, types and helpers of the rainfall grid step block
// ----------------------------------------------------------------------------
`default_nettype none

package rgs_pkg;

  localparam int MAX_DIM = 64;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int GRID_W  = 7;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  // ceil(2^17 / 3), exact floor division by three for values below 2^17
  localparam logic [16:0] RECIP3  = 17'd43691;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] CFG_GRID_SIZE  = 2'd0;
  localparam logic [1:0] CFG_RAIN_STEPS = 2'd1;
  localparam logic [1:0] CFG_SOAK_RATE  = 2'd2;

  typedef logic [3:0][15:0] nb_height_t;

  typedef struct packed {
    logic [3:0] mask;   // neighbors that receive a share
    logic [2:0] count;  // number of receiving neighbors
  } flow_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/rainfall_grid_step.sv =====
// ----------------------------------------------------------------------------
// rainfall_grid_step
// rainfall, absorption and trickle over a square grid of cells
// ----------------------------------------------------------------------------
// usage:
//   requests enter on in_valid/in_ready with op, row, col and elevation; each
//   request gives exactly one result on out_valid/out_ready.
//   a load writes one elevation and answers directly; a read answers via S_READ.
//   a step walks the grid in use twice, cell by cell, over the state memories:
//   pass 1 makes 5 height reads per cell, then absorbs and sends, and when the
//   cell trickles does one inflow read-modify-write per receiving neighbor;
//   pass 2 reads and writes each cell to fold inflows into water.
//   the pace of a step is set by the single port of the height memory and the
//   inflow read-modify-write sequence.
//   one request is worked at a time; a new one is taken while the previous
//   result leaves the output register.
//   after reset a clearing pass over all 4096 cells zeroes water, absorbed and
//   inflow memories; no request is taken then, config writes still land.
//   a stalled receiver holds the result register and blocks new requests.
//   config writes are single cycle and must come only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rainfall_grid_step import rgs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [5:0]  row,
  input  wire logic [5:0]  col,
  input  wire logic [15:0] elevation,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      absorbed_amount,
  output logic             all_dry,
  output logic [31:0]      steps_done
);

  // state codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_READ   = 4'd2;
  localparam logic [3:0] S_P1_RD  = 4'd3;
  localparam logic [3:0] S_P1_ABS = 4'd4;
  localparam logic [3:0] S_P1_SND = 4'd5;
  localparam logic [3:0] S_P1_INF = 4'd6;
  localparam logic [3:0] S_P2_RD  = 4'd7;
  localparam logic [3:0] S_P2_WR  = 4'd8;

  // config registers
  logic [GRID_W-1:0] grid_size;
  logic [15:0]       rain_steps;
  logic [31:0]       soak_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size  <= GRID_W'(MAX_DIM);
      rain_steps <= '0;
      soak_rate  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_SIZE:  grid_size  <= cfg_data[GRID_W-1:0];
        CFG_RAIN_STEPS: rain_steps <= cfg_data[15:0];
        CFG_SOAK_RATE:  soak_rate  <= cfg_data;
        default: ;
      endcase
    end
  end

  // grid side in use, clamped to 1..MAX_DIM
  logic [GRID_W-1:0] n;
  always_comb begin
    if (grid_size == '0) n = GRID_W'(1);
    else if (grid_size > GRID_W'(MAX_DIM)) n = GRID_W'(MAX_DIM);
    else n = grid_size;
  end

  // control and walk registers
  logic [3:0]        state;
  logic [2:0]        k;        // height read slot in pass 1
  logic [1:0]        d;        // neighbor in inflow update
  logic              ph;       // inflow read or write half
  logic [DIM_W-1:0]  r;
  logic [DIM_W-1:0]  c;
  logic [ADDR_W-1:0] clr_cnt;
  logic              wet;
  logic              rain;
  logic [31:0]       step_count;
  logic              dry_flag;

  // per cell working values
  logic [15:0]  h_own;
  nb_height_t   h_nb;
  logic [31:0]  w1;
  flow_t        flow;
  flow_t        flow_r;
  logic [16:0]  share;

  logic in_acc;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_acc   = in_valid && in_ready;

  // neighbors of the current cell
  logic [ADDR_W-1:0]       cell_addr;
  logic [3:0][ADDR_W-1:0]  nb_addr;
  logic [3:0]              nb_ok;
  logic                    last_c;
  logic                    last_r;

  assign cell_addr = {r, c};
  assign nb_addr[0] = {r - DIM_W'(1), c};
  assign nb_addr[1] = {r + DIM_W'(1), c};
  assign nb_addr[2] = {r, c - DIM_W'(1)};
  assign nb_addr[3] = {r, c + DIM_W'(1)};
  assign last_c = ({1'b0, c} + GRID_W'(1)) == n;
  assign last_r = ({1'b0, r} + GRID_W'(1)) == n;
  assign nb_ok[0] = (r != '0);
  assign nb_ok[1] = !last_r;
  assign nb_ok[2] = (c != '0);
  assign nb_ok[3] = !last_c;

  rgs_flow u_flow (
    .own_height (h_own),
    .nb_height  (h_nb),
    .nb_ok      (nb_ok),
    .flow       (flow)
  );

  // memories
  logic [15:0] h_mem [CELLS];
  logic [31:0] w_mem [CELLS];
  logic [31:0] a_mem [CELLS];
  logic [31:0] f_mem [CELLS];

  logic [ADDR_W-1:0] h_raddr, w_raddr, a_raddr, f_raddr;
  logic [ADDR_W-1:0] w_waddr, a_waddr, f_waddr;
  logic              w_we, a_we, f_we;
  logic [31:0]       w_wdata, a_wdata, f_wdata;
  logic [15:0]       h_rdata;
  logic [31:0]       w_rdata, a_rdata, f_rdata;

  always_ff @(posedge clk) begin
    if (in_acc && op == OP_LOAD) h_mem[{row, col}] <= elevation;
    h_rdata <= h_mem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_waddr] <= w_wdata;
    w_rdata <= w_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_waddr] <= a_wdata;
    a_rdata <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) f_mem[f_waddr] <= f_wdata;
    f_rdata <= f_mem[f_raddr];
  end

  // absorb arithmetic on the freshly read cell
  logic [31:0] w_rain, take;
  assign w_rain = rain ? sat_add(w_rdata, ONE_Q16) : w_rdata;
  assign take   = (w_rain < soak_rate) ? w_rain : soak_rate;

  // trickle amount and share per receiving neighbor
  logic [16:0] send;
  logic [33:0] prod3;
  logic [16:0] share_next;
  assign send  = (w1 < ONE_Q16) ? w1[16:0] : ONE_Q16[16:0];
  assign prod3 = send * RECIP3;
  always_comb begin
    unique case (flow_r.count)
      3'd2:    share_next = send >> 1;
      3'd3:    share_next = prod3[33:17];
      3'd4:    share_next = send >> 2;
      default: share_next = send;
    endcase
  end

  // memory address and write selection
  always_comb begin
    h_raddr = (k == 3'd0) ? cell_addr : nb_addr[2'(k - 3'd1)];
    w_raddr = cell_addr;
    a_raddr = (state == S_IDLE) ? {row, col} : cell_addr;
    f_raddr = (state == S_P1_INF) ? nb_addr[d] : cell_addr;
    w_waddr = cell_addr;
    a_waddr = cell_addr;
    f_waddr = (state == S_P1_INF) ? nb_addr[d] : cell_addr;
    w_we = 1'b0;
    a_we = 1'b0;
    f_we = 1'b0;
    w_wdata = '0;
    a_wdata = sat_add(a_rdata, take);
    f_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        w_waddr = clr_cnt;
        a_waddr = clr_cnt;
        f_waddr = clr_cnt;
        w_we = 1'b1;
        a_we = 1'b1;
        f_we = 1'b1;
        a_wdata = '0;
      end
      S_P1_ABS: a_we = 1'b1;
      S_P1_SND: begin
        w_we = 1'b1;
        w_wdata = (flow_r.mask != '0) ? w1 - {15'd0, send} : w1;
      end
      S_P1_INF: begin
        f_we = ph;
        f_wdata = sat_add(f_rdata, {15'd0, share});
      end
      S_P2_WR: begin
        w_we = 1'b1;
        f_we = 1'b1;
        w_wdata = sat_add(w_rdata, f_rdata);
      end
      default: ;
    endcase
  end

  // sequencer
  logic step_end;
  assign step_end = (state == S_P2_WR) && last_c && last_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      k          <= '0;
      d          <= '0;
      ph         <= 1'b0;
      r          <= '0;
      c          <= '0;
      wet        <= 1'b0;
      rain       <= 1'b0;
      step_count <= '0;
      dry_flag   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc && op == OP_STEP) begin
            state <= S_P1_RD;
            k     <= '0;
            r     <= '0;
            c     <= '0;
            wet   <= 1'b0;
            rain  <= step_count < {16'd0, rain_steps};
          end else if (in_acc && op == OP_READ) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_IDLE;
        S_P1_RD: begin
          k <= k + 3'd1;
          if (k == 3'd5) state <= S_P1_ABS;
        end
        S_P1_ABS: begin
          if (w_rain - take != '0) wet <= 1'b1;
          state <= S_P1_SND;
        end
        S_P1_SND: begin
          d  <= '0;
          ph <= 1'b0;
          k  <= '0;
          if (flow_r.mask != '0) begin
            state <= S_P1_INF;
          end else if (last_c) begin
            c <= '0;
            r <= last_r ? '0 : r + DIM_W'(1);
            state <= last_r ? S_P2_RD : S_P1_RD;
          end else begin
            c <= c + DIM_W'(1);
            state <= S_P1_RD;
          end
        end
        S_P1_INF: begin
          if (flow_r.mask[d] && !ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            d  <= d + 2'd1;
            if (d == 2'd3) begin
              if (last_c) begin
                c <= '0;
                r <= last_r ? '0 : r + DIM_W'(1);
                state <= last_r ? S_P2_RD : S_P1_RD;
              end else begin
                c <= c + DIM_W'(1);
                state <= S_P1_RD;
              end
            end
          end
        end
        S_P2_RD: state <= S_P2_WR;
        S_P2_WR: begin
          if (step_end) begin
            state    <= S_IDLE;
            dry_flag <= !wet;
            if (step_count != 32'hFFFF_FFFF) step_count <= step_count + 32'd1;
          end else begin
            state <= S_P2_RD;
            if (last_c) begin
              c <= '0;
              r <= r + DIM_W'(1);
            end else begin
              c <= c + DIM_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_P1_RD && k != 3'd0) begin
      if (k == 3'd1) h_own <= h_rdata;
      else h_nb[2'(k - 3'd2)] <= h_rdata;
    end
    if (state == S_P1_ABS) begin
      w1     <= w_rain - take;
      flow_r <= flow;
    end
    if (state == S_P1_SND) share <= share_next;
  end

  // result register
  logic res_load;
  logic [31:0] res_amount;
  always_comb begin
    res_load   = 1'b0;
    res_amount = '0;
    if (in_acc && op != OP_STEP && op != OP_READ) res_load = 1'b1;
    if (state == S_READ) begin
      res_load   = 1'b1;
      res_amount = a_rdata;
    end
    if (step_end) res_load = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      absorbed_amount <= res_amount;
      all_dry         <= step_end ? !wet : dry_flag;
      steps_done      <= (step_end && step_count != 32'hFFFF_FFFF) ?
                         step_count + 32'd1 : step_count;
    end
  end

  // checks
  `RGS_ASSERT_NOW(a_no_req_in_clear, clk, rst, state == S_CLEAR, !in_ready)
  `RGS_ASSERT_NEXT(a_step_starts, clk, rst, in_acc && op == OP_STEP, state == S_P1_RD && k == 3'd0)
  `RGS_ASSERT_NOW(a_p2_order, clk, rst, state == S_P2_WR, $past(state) == S_P2_RD)
  `RGS_ASSERT_NOW(a_inf_has_flow, clk, rst, state == S_P1_INF, flow_r.mask != 4'd0)

endmodule

`default_nettype wire

// ===== design/rgs_flow.sv =====
// ----------------------------------------------------------------------------
// rgs_flow
// picks the lowest strictly lower neighbors of one cell
// ----------------------------------------------------------------------------
`default_nettype none

module rgs_flow import rgs_pkg::*; (
  input  wire logic [15:0] own_height,
  input  wire nb_height_t  nb_height,
  input  wire logic [3:0]  nb_ok,
  output flow_t            flow
);

  logic [15:0] low;

  always_comb begin
    low = own_height;
    for (int d = 0; d < 4; d++) begin
      if (nb_ok[d] && nb_height[d] < low) low = nb_height[d];
    end
  end

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      flow.mask[d] = nb_ok[d] && (nb_height[d] == low) && (low < own_height);
    end
    flow.count = 3'($countones(flow.mask));
  end

endmodule

`default_nettype wire
